// ----- sv/pcpd_pkg.sv -----
`default_nettype none

package pcpd_pkg;

    localparam int CAP_W    = 16;
    localparam int OVF_W    = 16;
    localparam int PERIOD_W = 17;
    localparam int CLK_W    = 27;
    localparam int TICK_W   = 32;
    localparam int SUM_W    = TICK_W + 1;
    localparam int DUTY_W   = 7;
    localparam int CFG_IDX_W = 2;
    localparam int STEP_W   = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNTER_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_CLOCK_HZ = 2'd2;

    localparam logic              RST_MEASURE_MODE   = 1'b1;
    localparam logic [PERIOD_W-1:0] RST_COUNTER_PERIOD = 17'd65535;
    localparam logic [CLK_W-1:0]  RST_TIMER_CLOCK_HZ = 27'd8000000;

    localparam logic [DUTY_W-1:0] DUTY_SCALE = 7'd100;

    localparam logic [STEP_W-1:0] FREQ_STEPS = 5'd27;
    localparam logic [STEP_W-1:0] DUTY_STEPS = 5'd7;

    typedef enum logic [1:0] {
        DIV_FREQ,
        DIV_HIGH,
        DIV_LOW
    } div_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        logic     upd_en;
        logic     div_load;
        logic     div_step;
        logic     div_store;
        div_sel_t div_sel;
        logic     out_load;
    } pcpd_cmd_t;

    typedef struct packed {
        logic alt_mode;
    } pcpd_stat_t;

endpackage

`default_nettype wire

// ----- sv/pcpd_ctrl.sv -----
`default_nettype none

module pcpd_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  wire logic             out_stall,
    input  wire pcpd_pkg::pcpd_stat_t stat,
    output pcpd_pkg::pcpd_cmd_t   cmd
);
    import pcpd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_UPD,
        S_LOAD,
        S_RUN,
        S_STORE,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    div_sel_t           sel_reg, sel_next;
    logic [STEP_W-1:0]  count_reg, count_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        count_next = count_reg;
        cmd        = '0;
        cmd.div_sel = sel_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.upd_en = 1'b1;
                sel_next   = DIV_FREQ;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.div_load = 1'b1;
                count_next   = (sel_reg == DIV_FREQ) ? FREQ_STEPS - 1'b1 : DUTY_STEPS - 1'b1;
                state_next   = S_RUN;
            end
            S_RUN:
            begin
                cmd.div_step = 1'b1;
                count_next   = count_reg - 1'b1;
                if (count_reg == '0)
                begin
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                cmd.div_store = 1'b1;
                if (sel_reg == DIV_FREQ && stat.alt_mode)
                begin
                    sel_next   = DIV_HIGH;
                    state_next = S_LOAD;
                end
                else if (sel_reg == DIV_HIGH)
                begin
                    sel_next   = DIV_LOW;
                    state_next = S_LOAD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        out_valid_next = cmd.out_load ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= DIV_FREQ;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/pcpd_datapath.sv -----
`default_nettype none

module pcpd_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [pcpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pcpd_pkg::CLK_W-1:0]        cfg_data,
    input  wire logic [pcpd_pkg::CAP_W-1:0]        capture_value,
    input  wire logic [pcpd_pkg::OVF_W-1:0]        overflow_count,
    input  wire pcpd_pkg::pcpd_cmd_t               cmd,
    output pcpd_pkg::pcpd_stat_t                   stat,
    output logic                                   ready_res,
    output logic [pcpd_pkg::TICK_W-1:0]            interval_ticks,
    output logic [pcpd_pkg::TICK_W-1:0]            high_ticks,
    output logic [pcpd_pkg::TICK_W-1:0]            low_ticks,
    output logic [pcpd_pkg::CLK_W-1:0]             frequency_hz,
    output logic [pcpd_pkg::DUTY_W-1:0]            high_duty_percent,
    output logic [pcpd_pkg::DUTY_W-1:0]            low_duty_percent
);
    import pcpd_pkg::*;

    localparam int NUM_W = TICK_W + DUTY_W;

    // configuration
    logic                 mode_reg;
    logic [PERIOD_W-1:0]  period_reg;
    logic [CLK_W-1:0]     clk_hz_reg;

    // measurement state
    logic [TICK_W-1:0]    last_stamp_reg;
    logic                 awaiting_falling_reg;
    logic [TICK_W-1:0]    high_count_reg;
    logic [TICK_W-1:0]    low_count_reg;
    logic [TICK_W-1:0]    last_interval_reg;
    logic                 ready_reg;

    // input and stamp
    logic [CAP_W-1:0]             cap_reg;
    logic [OVF_W-1:0]             ovf_reg;
    logic [OVF_W+PERIOD_W-1:0]    prod_reg;
    logic [TICK_W-1:0]            stamp;
    logic [TICK_W-1:0]            diff;

    // shared restoring divider
    logic [SUM_W-1:0]     rem_reg;
    logic [CLK_W-1:0]     numsh_reg;
    logic [CLK_W-1:0]     quot_reg;
    logic [SUM_W-1:0]     den_reg;
    logic                 den_zero_reg;
    logic [SUM_W:0]       rem_shift;
    logic [SUM_W+1:0]     trial;
    logic                 ge;
    logic [SUM_W-1:0]     sum;
    logic [SUM_W-1:0]     load_den;
    logic [TICK_W-1:0]    duty_cnt;
    logic [NUM_W-1:0]     duty_num;

    logic [CLK_W-1:0]     freq_res_reg;
    logic [DUTY_W-1:0]    hduty_res_reg;
    logic [DUTY_W-1:0]    lduty_res_reg;

    assign stat.alt_mode = mode_reg;

    assign stamp = TICK_W'({16'd0, cap_reg} + prod_reg[TICK_W-1:0]);
    assign diff  = stamp - last_stamp_reg;

    assign sum       = {1'b0, high_count_reg} + {1'b0, low_count_reg};
    assign load_den  = mode_reg ? sum : {1'b0, last_interval_reg};
    assign duty_cnt  = (cmd.div_sel == DIV_HIGH) ? high_count_reg : low_count_reg;
    assign duty_num  = NUM_W'(duty_cnt) * NUM_W'(DUTY_SCALE);

    assign rem_shift = {rem_reg, numsh_reg[CLK_W-1]};
    assign trial     = {1'b0, rem_shift} - {2'b00, den_reg};
    assign ge        = !trial[SUM_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg             <= RST_MEASURE_MODE;
            period_reg           <= RST_COUNTER_PERIOD;
            clk_hz_reg           <= RST_TIMER_CLOCK_HZ;
            last_stamp_reg       <= '0;
            awaiting_falling_reg <= 1'b1;
            high_count_reg       <= '0;
            low_count_reg        <= '0;
            last_interval_reg    <= '0;
            ready_reg            <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_MEASURE_MODE:   mode_reg   <= cfg_data[0];
                    CFG_COUNTER_PERIOD: period_reg <= cfg_data[PERIOD_W-1:0];
                    CFG_TIMER_CLOCK_HZ: clk_hz_reg <= cfg_data;
                    default:            ;
                endcase
            end
            if (cmd.upd_en)
            begin
                if (stamp != last_stamp_reg)
                begin
                    last_stamp_reg <= stamp;
                    if (!mode_reg)
                    begin
                        last_interval_reg <= diff;
                        ready_reg         <= 1'b1;
                    end
                    else if (awaiting_falling_reg)
                    begin
                        high_count_reg       <= diff;
                        awaiting_falling_reg <= 1'b0;
                        ready_reg            <= (low_count_reg != '0);
                    end
                    else
                    begin
                        low_count_reg        <= diff;
                        awaiting_falling_reg <= 1'b1;
                        ready_reg            <= (high_count_reg != '0);
                    end
                end
                else
                begin
                    ready_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cap_reg <= capture_value;
            ovf_reg <= overflow_count;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= ovf_reg * period_reg;
        end
        if (cmd.div_load)
        begin
            quot_reg <= '0;
            if (cmd.div_sel == DIV_FREQ)
            begin
                rem_reg      <= '0;
                numsh_reg    <= clk_hz_reg;
                den_reg      <= load_den;
                den_zero_reg <= (load_den == '0);
            end
            else
            begin
                // quotient fits in the low DUTY_W bits, so start past the top
                rem_reg      <= SUM_W'(duty_num[NUM_W-1:DUTY_W]);
                numsh_reg    <= {duty_num[DUTY_W-1:0], {(CLK_W-DUTY_W){1'b0}}};
                den_reg      <= sum;
                den_zero_reg <= (sum == '0);
            end
        end
        else if (cmd.div_step)
        begin
            rem_reg   <= ge ? trial[SUM_W-1:0] : rem_shift[SUM_W-1:0];
            numsh_reg <= {numsh_reg[CLK_W-2:0], 1'b0};
            quot_reg  <= {quot_reg[CLK_W-2:0], ge};
        end
        if (cmd.div_store)
        begin
            case (cmd.div_sel)
                DIV_FREQ: freq_res_reg  <= den_zero_reg ? '0 : quot_reg;
                DIV_HIGH: hduty_res_reg <= den_zero_reg ? '0 : quot_reg[DUTY_W-1:0];
                DIV_LOW:  lduty_res_reg <= den_zero_reg ? '0 : quot_reg[DUTY_W-1:0];
                default:  ;
            endcase
        end
        if (cmd.out_load)
        begin
            ready_res         <= ready_reg;
            interval_ticks    <= mode_reg ? '0 : last_interval_reg;
            high_ticks        <= high_count_reg;
            low_ticks         <= low_count_reg;
            frequency_hz      <= freq_res_reg;
            high_duty_percent <= mode_reg ? hduty_res_reg : '0;
            low_duty_percent  <= mode_reg ? lduty_res_reg : '0;
        end
    end

endmodule

`default_nettype wire

// ----- sv/pulse_capture_period_duty.sv -----
// channel  direction  handshake             beat
// in       input      in_valid / in_stall   capture_value, overflow_count
// out      output     out_valid / out_stall ready_res .. low_duty_percent
// cfg      input      cfg_wr_en             cfg_index, cfg_data
//
// single-edge mode: one 27-step frequency divide from accept to result
// alternating mode: frequency then two 7-step duty divides on one divider
// one beat in flight; in_stall is high from the cycle after accept until the result is loaded
// result sits in an output register, so the next beat is taken while out_stall holds it
// rst_n is asynchronous and restores register and measurement reset values
`default_nettype none

module pulse_capture_period_duty (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [pcpd_pkg::CAP_W-1:0]        capture_value,
    input  wire logic [pcpd_pkg::OVF_W-1:0]        overflow_count,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   ready_res,
    output logic [pcpd_pkg::TICK_W-1:0]            interval_ticks,
    output logic [pcpd_pkg::TICK_W-1:0]            high_ticks,
    output logic [pcpd_pkg::TICK_W-1:0]            low_ticks,
    output logic [pcpd_pkg::CLK_W-1:0]             frequency_hz,
    output logic [pcpd_pkg::DUTY_W-1:0]            high_duty_percent,
    output logic [pcpd_pkg::DUTY_W-1:0]            low_duty_percent,
    input  wire logic                              cfg_wr_en,
    input  wire logic [pcpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pcpd_pkg::CLK_W-1:0]        cfg_data
);
    import pcpd_pkg::*;

    pcpd_cmd_t  cmd;
    pcpd_stat_t stat;

    pcpd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    pcpd_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .capture_value     (capture_value),
        .overflow_count    (overflow_count),
        .cmd               (cmd),
        .stat              (stat),
        .ready_res         (ready_res),
        .interval_ticks    (interval_ticks),
        .high_ticks        (high_ticks),
        .low_ticks         (low_ticks),
        .frequency_hz      (frequency_hz),
        .high_duty_percent (high_duty_percent),
        .low_duty_percent  (low_duty_percent)
    );

endmodule

`default_nettype wire

// ----- sv/pcpd_checker.sv -----
`default_nettype none

module pcpd_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire logic                              in_stall,
    input  wire logic                              out_valid,
    input  wire logic                              out_stall,
    input  wire logic [pcpd_pkg::TICK_W-1:0]       interval_ticks,
    input  wire logic [pcpd_pkg::TICK_W-1:0]       high_ticks,
    input  wire logic [pcpd_pkg::CLK_W-1:0]        frequency_hz,
    input  wire logic [pcpd_pkg::DUTY_W-1:0]       high_duty_percent,
    input  wire logic [pcpd_pkg::DUTY_W-1:0]       low_duty_percent
);
    import pcpd_pkg::*;

    // one beat in flight
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a beat is in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(high_ticks) && $stable(frequency_hz))
        else $error("stalled result changed");

    a_duty_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, high_duty_percent} + {1'b0, low_duty_percent}) <= 8'd100)
        else $error("duty percentages exceed 100");

    // interval is only reported in single-edge mode, where duty is zero
    a_single_no_duty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && interval_ticks != '0 |-> high_duty_percent == '0 && low_duty_percent == '0)
        else $error("duty reported with an interval");

endmodule

bind pulse_capture_period_duty pcpd_checker u_pcpd_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .interval_ticks    (interval_ticks),
    .high_ticks        (high_ticks),
    .frequency_hz      (frequency_hz),
    .high_duty_percent (high_duty_percent),
    .low_duty_percent  (low_duty_percent)
);

`default_nettype wire
